// ===== hw/rtl/glmrs_pkg.sv =====
package glmrs_pkg;

  localparam int REG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int H_W        = 4;
  localparam int RISK_W     = 18;
  localparam int CNT_W      = 15;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int SIZE_RESET = 100;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

  // one line buffer entry: cell of the row above and whether it may still be a low point
  typedef struct packed {
    logic           pend;
    logic [H_W-1:0] h;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // where a cell sits in the grid
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_row;
    logic last_col;
  } pos_t;

endpackage

// ===== hw/rtl/glmrs_ram.sv =====
module glmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/glmrs_front.sv =====
module glmrs_front #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128,
  parameter int AW = 7,
  parameter int RW = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [glmrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [glmrs_pkg::REG_W-1:0]       cfg_data_i,
  input  logic                              advance_i,
  output logic                              restart_o,
  output glmrs_pkg::pos_t                   pos_o,
  output logic [AW-1:0]                     col_o
);
  import glmrs_pkg::*;

  localparam int COLS_RST = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;
  localparam int ROWS_RST = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;

  logic [AW-1:0] cols_last_q, cols_last_d;
  logic [RW-1:0] rows_last_q, rows_last_d;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [31:0]   size_c, size_r;

  // out of range sizes: zero counts as one, too large counts as the maximum
  always_comb begin
    size_c = 32'(cfg_data_i);
    if (size_c == 32'd0) begin
      size_c = 32'd1;
    end else if (size_c > 32'(MAX_COLS)) begin
      size_c = 32'(MAX_COLS);
    end
    size_r = 32'(cfg_data_i);
    if (size_r == 32'd0) begin
      size_r = 32'd1;
    end else if (size_r > 32'(MAX_ROWS)) begin
      size_r = 32'(MAX_ROWS);
    end
  end

  assign restart_o = cfg_we_i && ((cfg_idx_i == CFG_COLS) || (cfg_idx_i == CFG_ROWS));

  assign pos_o.first_row = (row_q == '0);
  assign pos_o.first_col = (col_q == '0);
  assign pos_o.last_row  = (row_q == rows_last_q);
  assign pos_o.last_col  = (col_q == cols_last_q);
  assign col_o           = col_q;

  always_comb begin
    cols_last_d = cols_last_q;
    rows_last_d = rows_last_q;
    col_d       = col_q;
    row_d       = row_q;
    if (restart_o) begin
      col_d = '0;
      row_d = '0;
      if (cfg_idx_i == CFG_COLS) begin
        cols_last_d = AW'(size_c - 32'd1);
      end else begin
        rows_last_d = RW'(size_r - 32'd1);
      end
    end else if (advance_i) begin
      if (pos_o.last_col) begin
        col_d = '0;
        row_d = pos_o.last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_last_q <= AW'(COLS_RST - 1);
      rows_last_q <= RW'(ROWS_RST - 1);
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      cols_last_q <= cols_last_d;
      rows_last_q <= rows_last_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

endmodule

// ===== hw/rtl/glmrs_eval.sv =====
module glmrs_eval #(
  parameter int AW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          accept_i,
  input  logic [glmrs_pkg::H_W-1:0]     h_i,
  input  glmrs_pkg::pos_t               pos_i,
  input  logic [AW-1:0]                 col_i,
  input  glmrs_pkg::entry_t             rd_data_i,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output glmrs_pkg::entry_t             wdata_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_full_o,
  output logic [glmrs_pkg::RISK_W-1:0]  risk_o,
  output logic [glmrs_pkg::CNT_W-1:0]   count_o
);
  import glmrs_pkg::*;

  logic              s1_vld_q;
  logic [H_W-1:0]    s1_h_q;
  pos_t              s1_pos_q;
  logic [AW-1:0]     s1_col_q;
  logic              fwd_hit_q;
  entry_t            fwd_q;
  entry_t            tail_q;
  logic [H_W-1:0]    prev_h_q;
  logic              prev_p_q;
  logic [RISK_W-1:0] risk_q, risk_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_vld_q, out_vld_d;
  logic [RISK_W-1:0] out_risk_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              skid_vld_q, skid_vld_d;
  logic [RISK_W-1:0] skid_risk_q;
  logic [CNT_W-1:0]  skid_count_q;

  entry_t            above;
  logic              add_above, add_left, add_self;
  logic              cand, left_pend, final_cell;
  logic              pop, head_new, skid_new;
  logic [H_W:0]      t_above, t_left, t_self;

  // last column lives in a register, other columns in the ram (or a same-edge forward)
  always_comb begin
    if (s1_pos_q.last_col) begin
      above = tail_q;
    end else if (fwd_hit_q) begin
      above = fwd_q;
    end else begin
      above = rd_data_i;
    end
  end

  assign left_pend  = prev_p_q && (prev_h_q < s1_h_q);
  assign cand       = (s1_pos_q.first_row || (s1_h_q < above.h)) &&
                      (s1_pos_q.first_col || (s1_h_q < prev_h_q));
  assign add_above  = !s1_pos_q.first_row && above.pend && (above.h < s1_h_q);
  assign add_left   = !s1_pos_q.first_col && s1_pos_q.last_row && left_pend;
  assign add_self   = s1_pos_q.last_col && s1_pos_q.last_row && cand;
  assign final_cell = s1_vld_q && s1_pos_q.last_col && s1_pos_q.last_row;

  assign t_above = add_above ? {1'b0, above.h} + (H_W+1)'(1) : '0;
  assign t_left  = add_left  ? {1'b0, prev_h_q} + (H_W+1)'(1) : '0;
  assign t_self  = add_self  ? {1'b0, s1_h_q} + (H_W+1)'(1) : '0;

  assign risk_d  = risk_q + RISK_W'(t_above) + RISK_W'(t_left) + RISK_W'(t_self);
  assign count_d = count_q + CNT_W'(add_above) + CNT_W'(add_left) + CNT_W'(add_self);

  // left neighbor settles once the current cell is seen
  assign we_o         = s1_vld_q && !s1_pos_q.first_col && !s1_pos_q.last_row;
  assign waddr_o      = s1_col_q - AW'(1);
  assign wdata_o.pend = left_pend;
  assign wdata_o.h    = prev_h_q;

  // two result slots: the head drives the output, a second one catches a result behind it
  assign pop      = out_vld_q && out_ready_i;
  assign head_new = final_cell && !skid_vld_q && (pop || !out_vld_q);
  assign skid_new = final_cell && (pop ? skid_vld_q : out_vld_q);

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (pop) begin
      out_vld_d  = skid_vld_q || final_cell;
      skid_vld_d = skid_vld_q && final_cell;
    end else if (final_cell) begin
      out_vld_d  = 1'b1;
      skid_vld_d = out_vld_q;
    end
  end

  // no room for one more final cell in flight
  assign out_full_o = skid_vld_d;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_h_q   <= h_i;
      s1_pos_q <= pos_i;
      s1_col_q <= col_i;
    end
    fwd_q <= wdata_o;
    if (s1_vld_q && s1_pos_q.last_col && !s1_pos_q.last_row) begin
      tail_q.pend <= cand;
      tail_q.h    <= s1_h_q;
    end
    if (pop && skid_vld_q) begin
      out_risk_q  <= skid_risk_q;
      out_count_q <= skid_count_q;
    end else if (head_new) begin
      out_risk_q  <= risk_d;
      out_count_q <= count_d;
    end
    if (skid_new) begin
      skid_risk_q  <= risk_d;
      skid_count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      fwd_hit_q  <= 1'b0;
      prev_h_q   <= '0;
      prev_p_q   <= 1'b0;
      risk_q     <= '0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept_i;
      fwd_hit_q <= accept_i && we_o && (waddr_o == col_i);
      if (restart_i || final_cell) begin
        prev_h_q <= '0;
        prev_p_q <= 1'b0;
        risk_q   <= '0;
        count_q  <= '0;
      end else if (s1_vld_q) begin
        prev_h_q <= s1_h_q;
        prev_p_q <= cand;
        risk_q   <= risk_d;
        count_q  <= count_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign risk_o      = out_risk_q;
  assign count_o     = out_count_q;

endmodule

// ===== hw/rtl/grid_local_minimum_risk_sum.sv =====
// Grid low point risk sum. Heights arrive in raster order, one per input beat
// (row by row, left to right), and the grid size comes from cols_in_use and
// rows_in_use (zero counts as one, values above MAX_COLS / MAX_ROWS saturate).
// A cell is a low point when it is strictly lower than each of its existing
// up, down, left and right neighbors. A one-row line buffer in a ram keeps the
// height and a still-pending flag of the row above; the last column of that
// row sits in a register. On the final cell of a grid one output beat carries
// the sum of height+1 over all low points and their count, then the block
// starts on the next grid. Throughput is one cell per clock while tready is
// high: each cell needs one line buffer read and one write, and the ram gives
// one of each per cycle. The final cell passes the s1 stage registers, then
// its result is registered into a result slot. The output holds one result
// beat plus one more behind it; tready drops only when the final cell of a
// grid is due next while both result slots stay taken past the current edge.
// Writing either size register restarts the grid; write it only while the
// block is idle.
module grid_local_minimum_risk_sum #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [glmrs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [glmrs_pkg::REG_W-1:0]         cfg_data_i,
  // cell stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [glmrs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [3:0] height
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [17:0] risk_total, [32:18] low_count
  output logic [glmrs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import glmrs_pkg::*;

  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PAD = OUT_TDATA_W - RISK_W - CNT_W;

  logic              accept;
  logic              restart;
  pos_t              pos;
  logic [AW-1:0]     col;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic              out_valid;
  logic              out_full;
  logic [RISK_W-1:0] risk;
  logic [CNT_W-1:0]  count;

  // the final cell needs a free result slot by the time it is evaluated
  assign s_axis_tready = !(pos.last_col && pos.last_row && out_full);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // position counters and size registers
  glmrs_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW),
    .RW       (RW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (accept),
    .restart_o  (restart),
    .pos_o      (pos),
    .col_o      (col)
  );

  // line buffer: read of the current column issued at accept, data used by the following s1 stage
  glmrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (1 << AW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  // neighbor compares, accumulators and the result slots
  glmrs_eval #(
    .AW (AW)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .accept_i    (accept),
    .h_i         (s_axis_tdata[H_W-1:0]),
    .pos_i       (pos),
    .col_i       (col),
    .rd_data_i   (ram_rdata),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_valid),
    .out_full_o  (out_full),
    .risk_o      (risk),
    .count_o     (count)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD{1'b0}}, count, risk};

endmodule

// ===== hw/rtl/glmrs_checker.sv =====
module glmrs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [glmrs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import glmrs_pkg::*;

  logic [RISK_W-1:0] risk;
  logic [CNT_W-1:0]  count;

  assign risk  = m_axis_tdata[RISK_W-1:0];
  assign count = m_axis_tdata[RISK_W+CNT_W-1:RISK_W];

  // a waiting result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // each low point adds between 1 and 16 to the risk
  a_risk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (RISK_W+4)'(risk) >= (RISK_W+4)'(count) &&
                      (RISK_W+4)'(risk) <= ((RISK_W+4)'(count) << 4))
    else $error("risk total out of line with low count");

  // a new result only follows an input beat taken before it, through the s1 stage and a result slot
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a final cell");

  // padding above the fields stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:RISK_W+CNT_W] == '0)
    else $error("tdata padding not zero");

endmodule

bind grid_local_minimum_risk_sum glmrs_checker u_glmrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
